/* hdl/rpgt_pkg.sv */
// Shared types, widths and codes of the received packet gap tracker.
package rpgt_pkg;

   localparam int unsigned GAP_DEPTH_DEF = 16;
   localparam int unsigned PN_W          = 62;
   localparam int unsigned THR_W         = 8;
   localparam int unsigned GAP_CNT_W     = 5;
   localparam int unsigned STATUS_W      = 2;
   localparam int unsigned CSR_ADDR_W    = 2;
   localparam int unsigned CSR_DATA_W    = 8;
   localparam int unsigned REQ_TDATA_W   = 128;
   localparam int unsigned REQ_TUSER_W   = 2;
   localparam int unsigned RSP_TDATA_W   = 144;

   localparam logic [THR_W-1:0] THR_RESET = 8'd2;
   localparam logic [THR_W-1:0] THR_MAX   = 8'hFF;

   // configuration register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_THRESHOLD = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_USE_IMM   = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_DELAY     = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_UNEXPECTED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL       = 2'd2;

   typedef enum logic [1:0] {
      ACT_RECV,
      ACT_PEER_ACK,
      ACT_ACK_SENT,
      ACT_TIMEOUT
   } action_type;

   // how a late packet number relates to one missing range
   typedef enum logic [2:0] {
      HIT_NONE,
      HIT_BOTH,
      HIT_FIRST,
      HIT_LAST,
      HIT_INSIDE
   } hit_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_RD_IDX,
      OP_GAP_CHK,
      OP_IDX_INC,
      OP_RECV,
      OP_APPEND,
      OP_TRIM_FIRST,
      OP_TRIM_LAST,
      OP_SET_FULL,
      OP_SET_UNEXP,
      OP_DROP_SETUP,
      OP_SPLIT_SETUP,
      OP_FRONT_SETUP,
      OP_DN_RD,
      OP_DN_WR,
      OP_DN_END,
      OP_UP_RD,
      OP_UP_WR,
      OP_SPLIT_HI,
      OP_SPLIT_LO,
      OP_FRONT,
      OP_LOWEST,
      OP_PEER_SET,
      OP_KEEP_END,
      OP_ACK_SENT,
      OP_TIMEOUT,
      OP_PUBLISH
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      action_type act;
      hit_type    hit;
      logic       peer_go;   // peer ack moves the low edge
      logic       ooo;       // number differs from expected
      logic       ahead;     // number above expected
      logic       idx_end;   // scan index reached fill count
      logic       full;      // table full
      logic       keep;      // scanned range starts at or below low edge
      logic       below;     // number below low edge
      logic       adjacent;  // number just below low edge
      logic       down_end;  // downward move finished
      logic       up_end;    // upward move finished
      logic       rsp_free;  // result register can take a beat
   } dp_stat_type;

endpackage

/* hdl/rpgt_ram.sv */
// Generic single write port, single read port RAM with registered read.
module rpgt_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/rpgt_datapath.sv */
// Datapath: tracker state, range table RAM, compares and result register.
module rpgt_datapath #(
   parameter int unsigned GAP_DEPTH = rpgt_pkg::GAP_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [rpgt_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [rpgt_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic [rpgt_pkg::REQ_TDATA_W-1:0]    req_tdata,
   input  logic [rpgt_pkg::REQ_TUSER_W-1:0]    req_tuser,
   input  rpgt_pkg::dp_cmd_type                cmd,
   output rpgt_pkg::dp_stat_type               stat,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [rpgt_pkg::RSP_TDATA_W-1:0]    rsp_tdata
);

   localparam int unsigned PN_W   = rpgt_pkg::PN_W;
   localparam int unsigned WORD_W = 2 * PN_W;
   localparam int unsigned AW     = $clog2(GAP_DEPTH);
   localparam int unsigned CW     = $clog2(GAP_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(GAP_DEPTH);
   localparam int unsigned PAD_W  = rpgt_pkg::RSP_TDATA_W - 6 - 2 * PN_W
                                    - rpgt_pkg::GAP_CNT_W - rpgt_pkg::STATUS_W;

   // configuration
   logic [rpgt_pkg::THR_W-1:0] thr_ff, thr_in;
   logic                       imm_ff, imm_in;
   logic                       dly_ff, dly_in;

   // latched item
   rpgt_pkg::action_type act_ff, act_in;
   logic [PN_W-1:0]      pn_ff, pn_in;
   logic                 elic_ff, elic_in;
   logic                 ibit_ff, ibit_in;
   logic [PN_W-1:0]      pla_ff, pla_in;
   logic                 haf_ff, haf_in;

   // tracker state
   logic [PN_W-1:0]            largest_ff, largest_in;
   logic [PN_W-1:0]            lowest_ff, lowest_in;
   logic [PN_W-1:0]            expected_ff, expected_in;
   logic [PN_W-1:0]            last_elic_ff, last_elic_in;
   logic [rpgt_pkg::THR_W-1:0] since_ff, since_in;
   logic [1:0]                 info_ff, info_in;
   logic                       acknow_ff, acknow_in;
   logic                       timer_ff, timer_in;
   logic [CW-1:0]              used_ff, used_in;

   // work registers
   logic [CW-1:0]   idx_ff, idx_in;
   logic [CW-1:0]   src_ff, src_in;
   logic [CW-1:0]   dst_ff, dst_in;
   logic [CW-1:0]   tgt_ff, tgt_in;
   logic [PN_W-1:0] hit_first_ff, hit_first_in;
   logic [PN_W-1:0] hit_last_ff, hit_last_in;
   logic            gap_ff, gap_in;
   logic            start_ff, start_in;
   logic            cancel_ff, cancel_in;
   logic            ooo_ff, ooo_in;
   logic            upd_ff, upd_in;
   logic [rpgt_pkg::STATUS_W-1:0] status_ff, status_in;

   // result register
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [rpgt_pkg::RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   // RAM port
   logic              ram_we, ram_re;
   logic [AW-1:0]     ram_wa, ram_ra;
   logic [WORD_W-1:0] ram_wd, ram_rd;
   logic [PN_W-1:0]   rd_first, rd_last;

   logic [PN_W-1:0]            pn_inc, pn_dec, lowest_dec;
   logic [rpgt_pkg::THR_W-1:0] since_inc;
   logic                       ooo_c, force_now;
   logic [CW-1:0]              dst_dec;
   logic [CW+4:0]              used_ext;

   assign rd_first   = ram_rd[PN_W-1:0];
   assign rd_last    = ram_rd[WORD_W-1:PN_W];
   assign pn_inc     = pn_ff + PN_W'(1);
   assign pn_dec     = pn_ff - PN_W'(1);
   assign lowest_dec = lowest_ff - PN_W'(1);
   assign dst_dec    = dst_ff - CW'(1);
   assign ooo_c      = (pn_ff != expected_ff);
   assign since_inc  = (since_ff != rpgt_pkg::THR_MAX) ? since_ff + 8'd1 : since_ff;
   assign force_now  = (since_inc >= thr_ff) || ooo_c || gap_ff || (imm_ff && ibit_ff);
   assign used_ext   = {5'd0, used_ff};

   rpgt_ram #(
      .WIDTH (WORD_W),
      .DEPTH (GAP_DEPTH)
   ) u_ranges (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_en   (ram_re),
      .rd_addr (ram_ra),
      .rd_data (ram_rd)
   );

   // status toward the controller
   always_comb begin
      stat.act      = act_ff;
      stat.peer_go  = haf_ff && (pla_ff > lowest_ff);
      stat.ooo      = ooo_c;
      stat.ahead    = pn_ff > expected_ff;
      stat.idx_end  = (idx_ff == used_ff);
      stat.full     = (used_ff >= DEPTH_C);
      stat.keep     = (rd_first <= lowest_ff);
      stat.below    = (pn_ff < lowest_ff);
      stat.adjacent = (pn_inc == lowest_ff);
      stat.down_end = (src_ff == used_ff);
      stat.up_end   = (dst_ff == tgt_ff);
      stat.rsp_free = !rsp_valid_ff || rsp_tready;
      if (pn_ff == rd_first && pn_ff == rd_last) begin
         stat.hit = rpgt_pkg::HIT_BOTH;
      end else if (pn_ff == rd_first) begin
         stat.hit = rpgt_pkg::HIT_FIRST;
      end else if (pn_ff == rd_last) begin
         stat.hit = rpgt_pkg::HIT_LAST;
      end else if (pn_ff > rd_first && pn_ff < rd_last) begin
         stat.hit = rpgt_pkg::HIT_INSIDE;
      end else begin
         stat.hit = rpgt_pkg::HIT_NONE;
      end
   end

   always_comb begin
      thr_in       = thr_ff;
      imm_in       = imm_ff;
      dly_in       = dly_ff;
      act_in       = act_ff;
      pn_in        = pn_ff;
      elic_in      = elic_ff;
      ibit_in      = ibit_ff;
      pla_in       = pla_ff;
      haf_in       = haf_ff;
      largest_in   = largest_ff;
      lowest_in    = lowest_ff;
      expected_in  = expected_ff;
      last_elic_in = last_elic_ff;
      since_in     = since_ff;
      info_in      = info_ff;
      acknow_in    = acknow_ff;
      timer_in     = timer_ff;
      used_in      = used_ff;
      idx_in       = idx_ff;
      src_in       = src_ff;
      dst_in       = dst_ff;
      tgt_in       = tgt_ff;
      hit_first_in = hit_first_ff;
      hit_last_in  = hit_last_ff;
      gap_in       = gap_ff;
      start_in     = start_ff;
      cancel_in    = cancel_ff;
      ooo_in       = ooo_ff;
      upd_in       = upd_ff;
      status_in    = status_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = (rsp_valid_ff && rsp_tready) ? 1'b0 : rsp_valid_ff;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      ram_wa       = idx_ff[AW-1:0];
      ram_ra       = idx_ff[AW-1:0];
      ram_wd       = ram_rd;

      if (csr_we) begin
         unique case (csr_addr)
            rpgt_pkg::CSR_THRESHOLD: thr_in = csr_wdata;
            rpgt_pkg::CSR_USE_IMM:   imm_in = csr_wdata[0];
            rpgt_pkg::CSR_DELAY:     dly_in = csr_wdata[0];
            default: ;
         endcase
      end

      unique case (cmd.op)
         rpgt_pkg::OP_LOAD: begin
            act_in    = rpgt_pkg::action_type'(req_tuser);
            pn_in     = req_tdata[PN_W-1:0];
            elic_in   = req_tdata[PN_W];
            ibit_in   = req_tdata[PN_W+1];
            pla_in    = req_tdata[2*PN_W+1:PN_W+2];
            haf_in    = req_tdata[2*PN_W+2];
            idx_in    = '0;
            gap_in    = 1'b0;
            start_in  = 1'b0;
            cancel_in = 1'b0;
            ooo_in    = 1'b0;
            upd_in    = 1'b0;
            status_in = rpgt_pkg::STATUS_OK;
         end
         rpgt_pkg::OP_RD_IDX: begin
            ram_re = 1'b1;
         end
         rpgt_pkg::OP_GAP_CHK: begin
            gap_in = gap_ff || (rd_first >= last_elic_ff);
            idx_in = idx_ff + CW'(1);
         end
         rpgt_pkg::OP_IDX_INC: begin
            idx_in = idx_ff + CW'(1);
         end
         rpgt_pkg::OP_RECV: begin
            if (pn_ff > largest_ff || largest_ff == '0) begin
               upd_in     = (pn_ff != largest_ff);
               largest_in = pn_ff;
            end
            ooo_in  = ooo_c;
            info_in = info_ff | 2'b01;
            if (elic_ff) begin
               info_in  = info_ff | 2'b11;
               since_in = since_inc;
               if (!dly_ff) begin
                  acknow_in = 1'b1;
               end else if (force_now) begin
                  cancel_in = 1'b1;
                  timer_in  = 1'b0;
                  acknow_in = 1'b1;
               end else if (!timer_ff) begin
                  start_in = 1'b1;
                  timer_in = 1'b1;
               end
               last_elic_in = pn_ff;
            end
            if (!ooo_c) begin
               expected_in = pn_inc;
            end
            idx_in = '0;
         end
         rpgt_pkg::OP_APPEND: begin
            if (used_ff < DEPTH_C) begin
               ram_we  = 1'b1;
               ram_wa  = used_ff[AW-1:0];
               ram_wd  = {pn_dec, expected_ff};
               used_in = used_ff + CW'(1);
            end else begin
               status_in = rpgt_pkg::STATUS_FULL;
            end
            expected_in = pn_inc;
         end
         rpgt_pkg::OP_TRIM_FIRST: begin
            ram_we = 1'b1;
            ram_wd = {rd_last, pn_inc};
         end
         rpgt_pkg::OP_TRIM_LAST: begin
            ram_we = 1'b1;
            ram_wd = {pn_dec, rd_first};
         end
         rpgt_pkg::OP_SET_FULL: begin
            status_in = rpgt_pkg::STATUS_FULL;
         end
         rpgt_pkg::OP_SET_UNEXP: begin
            status_in = rpgt_pkg::STATUS_UNEXPECTED;
         end
         rpgt_pkg::OP_DROP_SETUP: begin
            src_in = idx_ff + CW'(1);
            dst_in = idx_ff;
         end
         rpgt_pkg::OP_SPLIT_SETUP: begin
            hit_first_in = rd_first;
            hit_last_in  = rd_last;
            dst_in       = used_ff;
            tgt_in       = idx_ff + CW'(1);
         end
         rpgt_pkg::OP_FRONT_SETUP: begin
            dst_in = used_ff;
            tgt_in = '0;
         end
         rpgt_pkg::OP_DN_RD: begin
            ram_re = 1'b1;
            ram_ra = src_ff[AW-1:0];
         end
         rpgt_pkg::OP_DN_WR: begin
            ram_we = 1'b1;
            ram_wa = dst_ff[AW-1:0];
            src_in = src_ff + CW'(1);
            dst_in = dst_ff + CW'(1);
         end
         rpgt_pkg::OP_DN_END: begin
            used_in = dst_ff;
         end
         rpgt_pkg::OP_UP_RD: begin
            ram_re = 1'b1;
            ram_ra = dst_dec[AW-1:0];
         end
         rpgt_pkg::OP_UP_WR: begin
            ram_we = 1'b1;
            ram_wa = dst_ff[AW-1:0];
            dst_in = dst_dec;
         end
         rpgt_pkg::OP_SPLIT_HI: begin
            ram_we  = 1'b1;
            ram_wa  = tgt_ff[AW-1:0];
            ram_wd  = {hit_last_ff, pn_inc};
            used_in = used_ff + CW'(1);
         end
         rpgt_pkg::OP_SPLIT_LO: begin
            ram_we = 1'b1;
            ram_wd = {pn_dec, hit_first_ff};
         end
         rpgt_pkg::OP_FRONT: begin
            ram_we    = 1'b1;
            ram_wa    = '0;
            ram_wd    = {lowest_dec, pn_inc};
            used_in   = used_ff + CW'(1);
            lowest_in = pn_ff;
         end
         rpgt_pkg::OP_LOWEST: begin
            lowest_in = pn_ff;
         end
         rpgt_pkg::OP_PEER_SET: begin
            lowest_in = pla_ff;
            idx_in    = '0;
         end
         rpgt_pkg::OP_KEEP_END: begin
            src_in = idx_ff;
            dst_in = '0;
         end
         rpgt_pkg::OP_ACK_SENT: begin
            if (dly_ff) begin
               cancel_in = 1'b1;
               timer_in  = 1'b0;
            end
            info_in   = 2'b00;
            acknow_in = 1'b0;
            since_in  = '0;
         end
         rpgt_pkg::OP_TIMEOUT: begin
            acknow_in = 1'b1;
            timer_in  = 1'b0;
         end
         rpgt_pkg::OP_PUBLISH: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = {PAD_W'(0), status_ff, info_ff[0],
                            used_ext[rpgt_pkg::GAP_CNT_W-1:0], lowest_ff, largest_ff,
                            upd_ff, ooo_ff, cancel_ff, start_ff, acknow_ff};
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff       <= rpgt_pkg::THR_RESET;
         imm_ff       <= 1'b0;
         dly_ff       <= 1'b1;
         largest_ff   <= '0;
         lowest_ff    <= '0;
         expected_ff  <= '0;
         last_elic_ff <= '0;
         since_ff     <= '0;
         info_ff      <= '0;
         acknow_ff    <= 1'b0;
         timer_ff     <= 1'b0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         thr_ff       <= thr_in;
         imm_ff       <= imm_in;
         dly_ff       <= dly_in;
         largest_ff   <= largest_in;
         lowest_ff    <= lowest_in;
         expected_ff  <= expected_in;
         last_elic_ff <= last_elic_in;
         since_ff     <= since_in;
         info_ff      <= info_in;
         acknow_ff    <= acknow_in;
         timer_ff     <= timer_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff       <= act_in;
      pn_ff        <= pn_in;
      elic_ff      <= elic_in;
      ibit_ff      <= ibit_in;
      pla_ff       <= pla_in;
      haf_ff       <= haf_in;
      idx_ff       <= idx_in;
      src_ff       <= src_in;
      dst_ff       <= dst_in;
      tgt_ff       <= tgt_in;
      hit_first_ff <= hit_first_in;
      hit_last_ff  <= hit_last_in;
      gap_ff       <= gap_in;
      start_ff     <= start_in;
      cancel_ff    <= cancel_in;
      ooo_ff       <= ooo_in;
      upd_ff       <= upd_in;
      status_ff    <= status_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

/* hdl/rpgt_ctrl.sv */
// Controller: sequences scans, range moves and result publication.
module rpgt_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  rpgt_pkg::dp_stat_type stat,
   output rpgt_pkg::dp_cmd_type  cmd
);

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_GAP_RD,
      ST_GAP_CHK,
      ST_RECV,
      ST_APPEND,
      ST_LATE_RD,
      ST_LATE_CHK,
      ST_BELOW,
      ST_KEEP_RD,
      ST_KEEP_CHK,
      ST_DN_RD,
      ST_DN_WR,
      ST_UP_RD,
      ST_UP_WR,
      ST_SPLIT_HI,
      ST_SPLIT_LO,
      ST_FRONT,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   state_type after_ff, after_in;   // where an upward move returns to

   always_comb begin
      state_in = state_ff;
      after_in = after_ff;
      cmd.op   = rpgt_pkg::OP_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.op   = rpgt_pkg::OP_LOAD;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            unique case (stat.act)
               rpgt_pkg::ACT_RECV: state_in = ST_GAP_RD;
               rpgt_pkg::ACT_PEER_ACK: begin
                  if (stat.peer_go) begin
                     cmd.op   = rpgt_pkg::OP_PEER_SET;
                     state_in = ST_KEEP_RD;
                  end else begin
                     state_in = ST_DONE;
                  end
               end
               rpgt_pkg::ACT_ACK_SENT: begin
                  cmd.op   = rpgt_pkg::OP_ACK_SENT;
                  state_in = ST_DONE;
               end
               rpgt_pkg::ACT_TIMEOUT: begin
                  cmd.op   = rpgt_pkg::OP_TIMEOUT;
                  state_in = ST_DONE;
               end
               default: state_in = ST_DONE;
            endcase
         end
         ST_GAP_RD: begin
            if (stat.idx_end) begin
               state_in = ST_RECV;
            end else begin
               cmd.op   = rpgt_pkg::OP_RD_IDX;
               state_in = ST_GAP_CHK;
            end
         end
         ST_GAP_CHK: begin
            cmd.op   = rpgt_pkg::OP_GAP_CHK;
            state_in = ST_GAP_RD;
         end
         ST_RECV: begin
            cmd.op = rpgt_pkg::OP_RECV;
            priority if (!stat.ooo) begin
               state_in = ST_DONE;
            end else if (stat.ahead) begin
               state_in = ST_APPEND;
            end else begin
               state_in = ST_LATE_RD;
            end
         end
         ST_APPEND: begin
            cmd.op   = rpgt_pkg::OP_APPEND;
            state_in = ST_DONE;
         end
         ST_LATE_RD: begin
            if (stat.idx_end) begin
               state_in = ST_BELOW;
            end else begin
               cmd.op   = rpgt_pkg::OP_RD_IDX;
               state_in = ST_LATE_CHK;
            end
         end
         ST_LATE_CHK: begin
            unique case (stat.hit)
               rpgt_pkg::HIT_NONE: begin
                  cmd.op   = rpgt_pkg::OP_IDX_INC;
                  state_in = ST_LATE_RD;
               end
               rpgt_pkg::HIT_BOTH: begin
                  cmd.op   = rpgt_pkg::OP_DROP_SETUP;
                  state_in = ST_DN_RD;
               end
               rpgt_pkg::HIT_FIRST: begin
                  cmd.op   = rpgt_pkg::OP_TRIM_FIRST;
                  state_in = ST_DONE;
               end
               rpgt_pkg::HIT_LAST: begin
                  cmd.op   = rpgt_pkg::OP_TRIM_LAST;
                  state_in = ST_DONE;
               end
               rpgt_pkg::HIT_INSIDE: begin
                  if (stat.full) begin
                     cmd.op   = rpgt_pkg::OP_SET_FULL;
                     state_in = ST_DONE;
                  end else begin
                     cmd.op   = rpgt_pkg::OP_SPLIT_SETUP;
                     after_in = ST_SPLIT_HI;
                     state_in = ST_UP_RD;
                  end
               end
               default: state_in = ST_DONE;
            endcase
         end
         ST_BELOW: begin
            priority if (!stat.below) begin
               cmd.op   = rpgt_pkg::OP_SET_UNEXP;
               state_in = ST_DONE;
            end else if (stat.adjacent) begin
               cmd.op   = rpgt_pkg::OP_LOWEST;
               state_in = ST_DONE;
            end else if (stat.full) begin
               cmd.op   = rpgt_pkg::OP_SET_FULL;
               state_in = ST_DONE;
            end else begin
               cmd.op   = rpgt_pkg::OP_FRONT_SETUP;
               after_in = ST_FRONT;
               state_in = ST_UP_RD;
            end
         end
         ST_KEEP_RD: begin
            if (stat.idx_end) begin
               cmd.op   = rpgt_pkg::OP_KEEP_END;
               state_in = ST_DN_RD;
            end else begin
               cmd.op   = rpgt_pkg::OP_RD_IDX;
               state_in = ST_KEEP_CHK;
            end
         end
         ST_KEEP_CHK: begin
            if (stat.keep) begin
               cmd.op   = rpgt_pkg::OP_IDX_INC;
               state_in = ST_KEEP_RD;
            end else begin
               cmd.op   = rpgt_pkg::OP_KEEP_END;
               state_in = ST_DN_RD;
            end
         end
         ST_DN_RD: begin
            if (stat.down_end) begin
               cmd.op   = rpgt_pkg::OP_DN_END;
               state_in = ST_DONE;
            end else begin
               cmd.op   = rpgt_pkg::OP_DN_RD;
               state_in = ST_DN_WR;
            end
         end
         ST_DN_WR: begin
            cmd.op   = rpgt_pkg::OP_DN_WR;
            state_in = ST_DN_RD;
         end
         ST_UP_RD: begin
            if (stat.up_end) begin
               state_in = after_ff;
            end else begin
               cmd.op   = rpgt_pkg::OP_UP_RD;
               state_in = ST_UP_WR;
            end
         end
         ST_UP_WR: begin
            cmd.op   = rpgt_pkg::OP_UP_WR;
            state_in = ST_UP_RD;
         end
         ST_SPLIT_HI: begin
            cmd.op   = rpgt_pkg::OP_SPLIT_HI;
            state_in = ST_SPLIT_LO;
         end
         ST_SPLIT_LO: begin
            cmd.op   = rpgt_pkg::OP_SPLIT_LO;
            state_in = ST_DONE;
         end
         ST_FRONT: begin
            cmd.op   = rpgt_pkg::OP_FRONT;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (stat.rsp_free) begin
               cmd.op   = rpgt_pkg::OP_PUBLISH;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         after_ff <= ST_DONE;
      end else begin
         state_ff <= state_in;
         after_ff <= after_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);

endmodule

/* hdl/received_packet_gap_tracker.sv */
// Top level of the received packet gap tracker.
// Keeps the packet numbers received in one number space as a sorted table of
// missing ranges (up to GAP_DEPTH entries, held in a RAM) plus the largest
// number seen, the next expected number and the lowest number still to be
// acknowledged, and decides per beat whether an ack goes out now or the ack
// delay timer is armed. The req beat carries an action in tuser (received,
// peer acked our ack frame, ack sent, delay timeout); every req beat yields
// exactly one rsp beat. One beat is worked at a time. The controller walks the
// range RAM entry by entry, reading an entry and then checking or writing it
// in separate states, so the work per beat grows with the ranges in use; ack
// sent and timeout walk no entries, and a range split or a new front range
// adds an upward move of table entries. A new req beat is taken while the
// previous rsp beat still waits in its output register. Configuration writes
// are taken at any cycle and must only be issued while the block is idle.
module received_packet_gap_tracker #(
   parameter int unsigned GAP_DEPTH = rpgt_pkg::GAP_DEPTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // configuration
   input  logic                             csr_we,
   input  logic [rpgt_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [rpgt_pkg::CSR_DATA_W-1:0]  csr_wdata,
   // request stream
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // packet_number, ack_eliciting, immediate_bit, peer_largest_acked,
   // has_ack_frame, zero pad
   input  logic [rpgt_pkg::REQ_TDATA_W-1:0] req_tdata,
   // action
   input  logic [rpgt_pkg::REQ_TUSER_W-1:0] req_tuser,
   // response stream
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // send_ack_now, start_delay_timer, cancel_delay_timer, out_of_order,
   // largest_updated, largest_received, smallest_to_ack, gap_count,
   // new_ack_info, status, zero pad
   output logic [rpgt_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   rpgt_pkg::dp_cmd_type  cmd;
   rpgt_pkg::dp_stat_type stat;

   rpgt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   rpgt_datapath #(
      .GAP_DEPTH (GAP_DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
